// ===== rtl/core/credit_link_vn_controller_core_assert.svh =====
// Assertion macros shared by the credit link controller checkers.
// Every macro samples on clock and is switched off while reset is high.
`ifndef CREDIT_LINK_VN_CONTROLLER_CORE_ASSERT_SVH
`define CREDIT_LINK_VN_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLVC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLVC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/clvc_pkg.sv =====
// Package of the credit link controller: types, codes, constants, helpers.
// Used by every module of the block but clvc_ram; depends on nothing.
package clvc_pkg;

   // Defaults of the top-level parameters.
   localparam int NUM_VN_DEFAULT      = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TAG_WIDTH_DEFAULT   = 16;

   // Fixed field widths.
   localparam int FLIT_W    = 12;
   localparam int NV_W      = 5;
   localparam int FB_W      = 11;
   localparam int SIZE_W    = 16;
   localparam int TAG_W     = 16;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int FQ_DEPTH  = 2;

   localparam logic [FLIT_W-1:0] CMAX      = 12'hFFF;
   localparam logic [FLIT_W-1:0] OBF_RESET = 12'd1024;
   localparam logic [FB_W-1:0]   FB_RESET  = 11'd64;
   localparam logic [3:0]        VNS_RESET = 4'd8;

   // Event codes.
   localparam logic [2:0] ACT_SEND  = 3'd0;
   localparam logic [2:0] ACT_QUERY = 3'd1;
   localparam logic [2:0] ACT_RECV  = 3'd2;
   localparam logic [2:0] ACT_RCRED = 3'd3;
   localparam logic [2:0] ACT_RDATA = 3'd4;
   localparam logic [2:0] ACT_TICK  = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FLIT_BITS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VNS_IN_USE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_BUF_FLITS = 2'd2;

   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        vn;
      logic [SIZE_W-1:0] size_bits;
      logic [FLIT_W-1:0] size_flits;
      logic [FLIT_W-1:0] credit_count;
      logic [TAG_W-1:0]  packet_tag;
   } req_payload_type;

   typedef struct packed {
      logic              ok;
      logic [2:0]        out_vn;
      logic [TAG_W-1:0]  out_tag;
      logic [FLIT_W-1:0] out_flits;
      logic [FLIT_W-1:0] credit_return;
   } rsp_payload_type;

   // A classified event as it waits between front and back.
   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        vn;
      logic              vn_ok;
      logic [SIZE_W-1:0] size_bits;
      logic [FLIT_W-1:0] size_flits;
      logic [FLIT_W-1:0] credit_count;
      logic [TAG_W-1:0]  packet_tag;
   } item_type;

   // Head of the event queue as the back end sees it.
   typedef struct packed {
      logic     valid;
      item_type item;
   } fq_type;

   // Decoded configuration.
   typedef struct packed {
      logic [FB_W-1:0]   fb;
      logic [NV_W-1:0]   nv;
      logic [FLIT_W-1:0] obf;
      logic              reload;
   } cfg_type;

   // Counter add that sticks at the maximum.
   function automatic logic [FLIT_W-1:0] sat_add(input logic [FLIT_W-1:0] a,
                                                 input logic [FLIT_W-1:0] b);
      logic [FLIT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FLIT_W] ? CMAX : s[FLIT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/credit_link_vn_controller_core.sv =====
// Top level of the credit link controller: configuration registers,
// front end and back end. Uses clvc_pkg, clvc_front and clvc_back.
//
// Usage: an event is transferred at a clock edge with start high and busy
// low; its fields come on req_data. Every event gives exactly one result,
// shown on rsp_data for a single cycle with rsp_valid high. The receiver
// cannot hold results off; they are taken as they appear.
// Router credit, router data, unused codes, an empty receive and an idle
// tick give their result from the execute state; a space query, a receive
// that finds a packet and a tick that sends one pass a query, receive or
// tick state first. A send passes the bit-serial divider that rounds the
// bit size up to flits, one quotient bit per cycle over 17 bits.
// The back end works on one event at a time; after a tick that sends a
// packet it reloads the queue head from the queue RAM if packets remain. A
// two-entry event queue in front lets start be taken while the back end is
// at work; busy rises when it is full.
// Configuration: csr_we writes csr_wdata to register csr_index, and may only
// be used while no event is pending.
// Reset (synchronous) empties all queues, clears router credits and the
// round-robin pointer, and loads output credits with 1024 flits.
module credit_link_vn_controller_core import clvc_pkg::*; #(
   parameter int NUM_VN      = NUM_VN_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [FB_W-1:0]   flit_bits_ff, flit_bits_in;
   logic [3:0]        vns_ff, vns_in;
   logic [FLIT_W-1:0] obf_ff, obf_in;
   logic              reload_ff, reload_in;
   cfg_type           cfg;
   fq_type            fq;
   logic              pop;

   // Configuration register writes.
   always_comb begin
      flit_bits_in = flit_bits_ff;
      vns_in       = vns_ff;
      obf_in       = obf_ff;
      reload_in    = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            REG_FLIT_BITS:     flit_bits_in = csr_wdata[FB_W-1:0];
            REG_VNS_IN_USE:    vns_in       = csr_wdata[3:0];
            REG_OUT_BUF_FLITS: begin
               obf_in    = csr_wdata;
               reload_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flit_bits_ff <= FB_RESET;
         vns_ff       <= VNS_RESET;
         obf_ff       <= OBF_RESET;
         reload_ff    <= 1'b0;
      end else begin
         flit_bits_ff <= flit_bits_in;
         vns_ff       <= vns_in;
         obf_ff       <= obf_in;
         reload_ff    <= reload_in;
      end
   end

   // Effective flit size and VN count.
   always_comb begin
      cfg.fb = (flit_bits_ff == '0) ? FB_W'(1) : flit_bits_ff;
      if (vns_ff == '0) begin
         cfg.nv = NV_W'(1);
      end else if (NV_W'(vns_ff) > NV_W'(NUM_VN)) begin
         cfg.nv = NV_W'(NUM_VN);
      end else begin
         cfg.nv = NV_W'(vns_ff);
      end
      cfg.obf    = obf_ff;
      cfg.reload = reload_ff;
   end

   clvc_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .req   (req_data),
      .nv    (cfg.nv),
      .fq    (fq),
      .pop   (pop)
   );

   clvc_back #(
      .NUM_VN      (NUM_VN),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fq        (fq),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

// ===== rtl/core/clvc_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// Standalone; used for the packet queues of the credit link controller.
module clvc_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/clvc_front.sv =====
// Front end of the credit link controller: takes events, checks the VN,
// and holds them in a two-entry queue for the back end. Uses clvc_pkg.
module clvc_front import clvc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req,
   input  logic [NV_W-1:0] nv,
   output fq_type          fq,
   input  logic            pop
);

   localparam int FQ_PW = $clog2(FQ_DEPTH);
   localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

   item_type           q_ff [FQ_DEPTH];
   logic [FQ_PW-1:0]   wr_ff, wr_in;
   logic [FQ_PW-1:0]   rd_ff, rd_in;
   logic [FQ_CW-1:0]   cnt_ff, cnt_in;
   logic               push;
   logic               do_pop;
   item_type           cls;

   // Classify the incoming event.
   always_comb begin
      cls.action       = req.action;
      cls.vn           = req.vn;
      cls.vn_ok        = (NV_W'(req.vn) < nv);
      cls.size_bits    = req.size_bits;
      cls.size_flits   = req.size_flits;
      cls.credit_count = req.credit_count;
      cls.packet_tag   = req.packet_tag;
   end

   assign busy   = (cnt_ff == FQ_CW'(FQ_DEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (cnt_ff != '0);

   // Queue pointers and fill count.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == FQ_PW'(FQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == FQ_PW'(FQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

   assign fq.valid = (cnt_ff != '0);
   assign fq.item  = q_ff[rd_ff];

endmodule

// ===== rtl/core/clvc_back.sv =====
// Back end of the credit link controller: carries out one event at a time
// against the VN queues and credit counters. Uses clvc_pkg and clvc_ram.
module clvc_back import clvc_pkg::*; #(
   parameter int NUM_VN      = NUM_VN_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  fq_type          fq,
   output logic            pop,
   output logic            rsp_valid,
   output rsp_payload_type rsp
);

   localparam int VN_W = (NUM_VN > 1) ? $clog2(NUM_VN) : 1;
   localparam int PW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int MD   = NUM_VN * QUEUE_DEPTH;
   localparam int AW   = (MD > 1) ? $clog2(MD) : 1;
   localparam int EW   = TAG_WIDTH + FLIT_W;
   localparam int DW   = SIZE_W + 1;
   localparam int DCW  = $clog2(DW + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SEND  = 4'd3;
   localparam logic [3:0] S_QUERY = 4'd4;
   localparam logic [3:0] S_RECV  = 4'd5;
   localparam logic [3:0] S_TICK  = 4'd6;
   localparam logic [3:0] S_HEAD  = 4'd7;

   logic [3:0]        state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic [CW-1:0]     out_cnt_ff  [NUM_VN], out_cnt_in  [NUM_VN];
   logic [PW-1:0]     out_head_ff [NUM_VN], out_head_in [NUM_VN];
   logic [PW-1:0]     out_tail_ff [NUM_VN], out_tail_in [NUM_VN];
   logic [CW-1:0]     in_cnt_ff   [NUM_VN], in_cnt_in   [NUM_VN];
   logic [PW-1:0]     in_head_ff  [NUM_VN], in_head_in  [NUM_VN];
   logic [PW-1:0]     in_tail_ff  [NUM_VN], in_tail_in  [NUM_VN];
   logic [FLIT_W-1:0] hflits_ff   [NUM_VN], hflits_in   [NUM_VN];
   logic [FLIT_W-1:0] obc_ff      [NUM_VN], obc_in      [NUM_VN];
   logic [FLIT_W-1:0] rc_ff       [NUM_VN], rc_in       [NUM_VN];
   logic [VN_W-1:0]   rr_ff, rr_in;
   logic [VN_W-1:0]   sel_ff, sel_in;
   logic [DW-1:0]     num_ff, num_in;
   logic [FB_W-1:0]   rem_ff, rem_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [DCW-1:0]    dcnt_ff, dcnt_in;
   logic [22:0]       prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              out_we, in_we;
   logic [AW-1:0]     out_waddr, out_raddr, in_waddr, in_raddr;
   logic [EW-1:0]     out_wdata, in_wdata, out_rdata, in_rdata;

   logic [VN_W-1:0]   vi;
   logic [TAG_WIDTH-1:0] tagw;
   logic [FB_W:0]     r2;
   logic              found;
   logic [VN_W-1:0]   sel;
   logic [VN_W-1:0]   start_vn;
   logic [NV_W:0]     cand;
   logic [FLIT_W-1:0] ent_flits;
   logic [TAG_WIDTH-1:0] ent_tag;
   logic [CW-1:0]     left;

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] addr(input logic [VN_W-1:0] v,
                                          input logic [PW-1:0] p);
      return AW'(int'(v) * QUEUE_DEPTH + int'(p));
   endfunction

   assign vi   = VN_W'(cur_ff.vn);
   assign tagw = TAG_WIDTH'(cur_ff.packet_tag);
   assign r2   = {rem_ff, num_ff[DW-1]};

   // Round-robin pick of the first VN whose head packet fits its credits.
   always_comb begin
      found    = 1'b0;
      sel      = '0;
      cand     = '0;
      start_vn = (NV_W'(rr_ff) < cfg.nv) ? rr_ff : '0;
      for (int i = 0; i < NUM_VN; i++) begin
         cand = (NV_W + 1)'(start_vn) + (NV_W + 1)'(i);
         if (cand >= {1'b0, cfg.nv}) begin
            cand = cand - {1'b0, cfg.nv};
         end
         if (!found && (NV_W'(i) < cfg.nv) && (out_cnt_ff[VN_W'(cand)] != '0) &&
             (rc_ff[VN_W'(cand)] >= hflits_ff[VN_W'(cand)])) begin
            found = 1'b1;
            sel   = VN_W'(cand);
         end
      end
   end

   // Queue entry fields as they come out of the RAMs.
   assign ent_flits = (state_ff == S_RECV) ? in_rdata[FLIT_W-1:0] : out_rdata[FLIT_W-1:0];
   assign ent_tag   = (state_ff == S_RECV) ? in_rdata[EW-1:FLIT_W] : out_rdata[EW-1:FLIT_W];

   // Event sequencer.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      out_cnt_in   = out_cnt_ff;
      out_head_in  = out_head_ff;
      out_tail_in  = out_tail_ff;
      in_cnt_in    = in_cnt_ff;
      in_head_in   = in_head_ff;
      in_tail_in   = in_tail_ff;
      hflits_in    = hflits_ff;
      obc_in       = obc_ff;
      rc_in        = rc_ff;
      rr_in        = rr_ff;
      sel_in       = sel_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pop          = 1'b0;
      out_we       = 1'b0;
      out_waddr    = '0;
      out_wdata    = '0;
      out_raddr    = '0;
      in_we        = 1'b0;
      in_waddr     = '0;
      in_wdata     = '0;
      in_raddr     = '0;
      left         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (fq.valid) begin
               pop      = 1'b1;
               cur_in   = fq.item;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_IDLE;
            unique case (cur_ff.action)
               ACT_SEND: begin
                  num_in   = DW'(cur_ff.size_bits) + DW'(cfg.fb) - 1'b1;
                  rem_in   = '0;
                  quo_in   = '0;
                  dcnt_in  = DCW'(DW);
                  state_in = S_DIV;
               end
               ACT_QUERY: begin
                  prod_in  = 23'(obc_ff[vi]) * 23'(cfg.fb);
                  state_in = S_QUERY;
               end
               ACT_RECV: begin
                  if (cur_ff.vn_ok && in_cnt_ff[vi] != '0) begin
                     in_raddr = addr(vi, in_head_ff[vi]);
                     state_in = S_RECV;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               ACT_RCRED: begin
                  rsp_valid_in = 1'b1;
                  if (cur_ff.vn_ok) begin
                     rc_in[vi] = sat_add(rc_ff[vi], cur_ff.credit_count);
                     rsp_in.ok = 1'b1;
                  end
               end
               ACT_RDATA: begin
                  rsp_valid_in = 1'b1;
                  if (cur_ff.vn_ok && in_cnt_ff[vi] != CW'(QUEUE_DEPTH)) begin
                     in_we          = 1'b1;
                     in_waddr       = addr(vi, in_tail_ff[vi]);
                     in_wdata       = {tagw, cur_ff.size_flits};
                     in_tail_in[vi] = nxt(in_tail_ff[vi]);
                     in_cnt_in[vi]  = in_cnt_ff[vi] + 1'b1;
                     rsp_in.ok      = 1'b1;
                  end
               end
               ACT_TICK: begin
                  if (found) begin
                     out_raddr = addr(sel, out_head_ff[sel]);
                     sel_in    = sel;
                     state_in  = S_TICK;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end

         // Restoring division, one quotient bit per cycle.
         S_DIV: begin
            if (r2 >= {1'b0, cfg.fb}) begin
               rem_in = FB_W'(r2 - {1'b0, cfg.fb});
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = r2[FB_W-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            num_in  = {num_ff[DW-2:0], 1'b0};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DCW'(1)) begin
               state_in = S_SEND;
            end
         end

         S_SEND: begin
            rsp_valid_in     = 1'b1;
            rsp_in.out_vn    = cur_ff.vn;
            rsp_in.out_tag   = TAG_W'(tagw);
            rsp_in.out_flits = (quo_ff > DW'(CMAX)) ? CMAX : quo_ff[FLIT_W-1:0];
            if (cur_ff.vn_ok && DW'(obc_ff[vi]) >= quo_ff &&
                out_cnt_ff[vi] != CW'(QUEUE_DEPTH)) begin
               obc_in[vi]      = obc_ff[vi] - quo_ff[FLIT_W-1:0];
               out_we          = 1'b1;
               out_waddr       = addr(vi, out_tail_ff[vi]);
               out_wdata       = {tagw, quo_ff[FLIT_W-1:0]};
               out_tail_in[vi] = nxt(out_tail_ff[vi]);
               out_cnt_in[vi]  = out_cnt_ff[vi] + 1'b1;
               if (out_cnt_ff[vi] == '0) begin
                  hflits_in[vi] = quo_ff[FLIT_W-1:0];
               end
               rsp_in.ok = 1'b1;
            end
            state_in = S_IDLE;
         end

         S_QUERY: begin
            rsp_valid_in = 1'b1;
            rsp_in.ok    = cur_ff.vn_ok && (prod_ff >= 23'(cur_ff.size_bits));
            state_in     = S_IDLE;
         end

         S_RECV: begin
            rsp_valid_in         = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.out_vn        = cur_ff.vn;
            rsp_in.out_tag       = TAG_W'(ent_tag);
            rsp_in.out_flits     = ent_flits;
            rsp_in.credit_return = ent_flits;
            in_head_in[vi]       = nxt(in_head_ff[vi]);
            in_cnt_in[vi]        = in_cnt_ff[vi] - 1'b1;
            state_in             = S_IDLE;
         end

         // Send the picked head packet toward the router.
         S_TICK: begin
            rsp_valid_in         = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.out_vn        = 3'(sel_ff);
            rsp_in.out_tag       = TAG_W'(ent_tag);
            rsp_in.out_flits     = hflits_ff[sel_ff];
            obc_in[sel_ff]       = sat_add(obc_ff[sel_ff], hflits_ff[sel_ff]);
            rc_in[sel_ff]        = rc_ff[sel_ff] - hflits_ff[sel_ff];
            rr_in                = (NV_W'(sel_ff) + 1'b1 == cfg.nv) ? '0 : sel_ff + 1'b1;
            left                 = out_cnt_ff[sel_ff] - 1'b1;
            out_cnt_in[sel_ff]   = left;
            out_head_in[sel_ff]  = nxt(out_head_ff[sel_ff]);
            if (left != '0) begin
               out_raddr = addr(sel_ff, nxt(out_head_ff[sel_ff]));
               state_in  = S_HEAD;
            end else begin
               state_in  = S_IDLE;
            end
         end

         // Refresh the cached flit count of the new head packet.
         S_HEAD: begin
            hflits_in[sel_ff] = ent_flits;
            state_in          = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write of the buffer size register reloads every output credit.
      if (cfg.reload) begin
         for (int i = 0; i < NUM_VN; i++) begin
            obc_in[i] = cfg.obf;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VN; i++) begin
            out_cnt_ff[i]  <= '0;
            out_head_ff[i] <= '0;
            out_tail_ff[i] <= '0;
            in_cnt_ff[i]   <= '0;
            in_head_ff[i]  <= '0;
            in_tail_ff[i]  <= '0;
            obc_ff[i]      <= OBF_RESET;
            rc_ff[i]       <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rr_ff        <= rr_in;
         rsp_valid_ff <= rsp_valid_in;
         out_cnt_ff   <= out_cnt_in;
         out_head_ff  <= out_head_in;
         out_tail_ff  <= out_tail_in;
         in_cnt_ff    <= in_cnt_in;
         in_head_ff   <= in_head_in;
         in_tail_ff   <= in_tail_in;
         obc_ff       <= obc_in;
         rc_ff        <= rc_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      hflits_ff <= hflits_in;
      sel_ff    <= sel_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   // Outgoing and incoming packet queues.
   clvc_ram #(.WIDTH(EW), .DEPTH(MD)) u_out_ram (
      .clock (clock),
      .we    (out_we),
      .waddr (out_waddr),
      .wdata (out_wdata),
      .raddr (out_raddr),
      .rdata (out_rdata)
   );

   clvc_ram #(.WIDTH(EW), .DEPTH(MD)) u_in_ram (
      .clock (clock),
      .we    (in_we),
      .waddr (in_waddr),
      .wdata (in_wdata),
      .raddr (in_raddr),
      .rdata (in_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/clvc_checker.sv =====
// Port-level checks of the credit link controller, bound to the top level.
// Uses clvc_pkg and the assertion macros of the project header.
`include "credit_link_vn_controller_core_assert.svh"

module clvc_checker import clvc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input rsp_payload_type rsp_data
);

   logic cret_nz;

   // A result that hands credits back to the router.
   assign cret_nz = rsp_valid && (rsp_data.credit_return != '0);

   // No state that gives a result is followed by another that does, so results never abut.
   `CLVC_ASSERT_NXT(a_rsp_gap, rsp_valid, !rsp_valid)

   // Credits come back only from a successful receive.
   `CLVC_ASSERT_IMP(a_cret_ok, cret_nz, rsp_data.ok)

   // Returned credits equal the flit size of the received packet.
   `CLVC_ASSERT_IMP(a_cret_flits, cret_nz, rsp_data.credit_return == rsp_data.out_flits)

endmodule

bind credit_link_vn_controller_core clvc_checker u_clvc_checker (.*);

// ===== dv/credit_link_vn_controller_core_checker.sv =====
// Checker for the credit link controller: watches event and result transfers,
// predicts each result from its own copy of the link state and compares.
// Depends on clvc_pkg; configuration writes are observed on the csr port.
`timescale 1ns / 100ps
module credit_link_vn_controller_core_checker import clvc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_payload_type      req_data,
   input  logic                 rsp_valid,
   input  rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending_count,
   output logic                 transfer_seen
);

   localparam int NVN = 8;
   localparam int QD  = 16;

   typedef struct {
      logic [TAG_W-1:0]  tag;
      logic [FLIT_W-1:0] flits;
   } pkt_type;

   pkt_type           out_q[NVN][$];
   pkt_type           in_q[NVN][$];
   logic [FLIT_W-1:0] obuf_credit[NVN];
   logic [FLIT_W-1:0] rtr_credit[NVN];
   int                rr_ptr;
   logic [FB_W-1:0]   flit_bits;
   logic [3:0]        vns_in_use;
   rsp_payload_type   expected_rsp[$];

   assign pending_count = expected_rsp.size();
   assign transfer_seen = (start && !busy) || rsp_valid;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // Work out the result of one event and update the link state.
   function automatic rsp_payload_type link_event(input req_payload_type ev);
      rsp_payload_type   r;
      int                nv, fb, flits, st, v;
      logic              vn_ok;
      pkt_type           p;
      r = '0;
      nv = (vns_in_use == 0) ? 1 : (vns_in_use > NVN ? NVN : vns_in_use);
      fb = (flit_bits == 0) ? 1 : flit_bits;
      vn_ok = ev.vn < nv;
      case (ev.action)
         ACT_SEND: begin
            flits = (ev.size_bits + fb - 1) / fb;
            r.out_vn = ev.vn;
            r.out_tag = ev.packet_tag;
            r.out_flits = (flits > 4095) ? CMAX : flits[FLIT_W-1:0];
            if (vn_ok && obuf_credit[ev.vn] >= flits && out_q[ev.vn].size() < QD) begin
               obuf_credit[ev.vn] -= flits[FLIT_W-1:0];
               p.tag = ev.packet_tag;
               p.flits = flits[FLIT_W-1:0];
               out_q[ev.vn].insert(out_q[ev.vn].size(), p);
               r.ok = 1'b1;
            end
         end
         ACT_QUERY: r.ok = vn_ok && (longint'(obuf_credit[ev.vn]) * fb >= ev.size_bits);
         ACT_RECV: begin
            if (vn_ok && in_q[ev.vn].size() > 0) begin
               p = in_q[ev.vn][0];
               in_q[ev.vn].delete(0);
               r.ok = 1'b1;
               r.out_vn = ev.vn;
               r.out_tag = p.tag;
               r.out_flits = p.flits;
               r.credit_return = p.flits;
            end
         end
         ACT_RCRED: begin
            if (vn_ok) begin
               rtr_credit[ev.vn] = (rtr_credit[ev.vn] + ev.credit_count > 4095) ? CMAX :
                  rtr_credit[ev.vn] + ev.credit_count;
               r.ok = 1'b1;
            end
         end
         ACT_RDATA: begin
            if (vn_ok && in_q[ev.vn].size() < QD) begin
               p.tag = ev.packet_tag;
               p.flits = ev.size_flits;
               in_q[ev.vn].insert(in_q[ev.vn].size(), p);
               r.ok = 1'b1;
            end
         end
         ACT_TICK: begin
            // Round-robin search for the first head that fits router credits.
            st = (rr_ptr < nv) ? rr_ptr : 0;
            for (int i = 0; i < nv; i++) begin
               v = (st + i) % nv;
               if (out_q[v].size() == 0) continue;
               if (rtr_credit[v] < out_q[v][0].flits) continue;
               p = out_q[v][0];
               out_q[v].delete(0);
               obuf_credit[v] = (obuf_credit[v] + p.flits > 4095) ? CMAX :
                  obuf_credit[v] + p.flits;
               rtr_credit[v] -= p.flits;
               rr_ptr = (v + 1 == nv) ? 0 : v + 1;
               r.ok = 1'b1;
               r.out_vn = v;
               r.out_tag = p.tag;
               r.out_flits = p.flits;
               break;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < NVN; i++) begin
            out_q[i].delete();
            in_q[i].delete();
            obuf_credit[i] = OBF_RESET;
            rtr_credit[i] = '0;
         end
         rr_ptr = 0;
         flit_bits = FB_RESET;
         vns_in_use = VNS_RESET;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         // Results are checked before the event of this same edge is predicted.
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_data.ok !== want.ok) report_mismatch("ok", rsp_data.ok, want.ok);
               if (rsp_data.out_vn !== want.out_vn)
                  report_mismatch("out_vn", rsp_data.out_vn, want.out_vn);
               if (rsp_data.out_tag !== want.out_tag)
                  report_mismatch("out_tag", rsp_data.out_tag, want.out_tag);
               if (rsp_data.out_flits !== want.out_flits)
                  report_mismatch("out_flits", rsp_data.out_flits, want.out_flits);
               if (rsp_data.credit_return !== want.credit_return)
                  report_mismatch("credit_return", rsp_data.credit_return,
                     want.credit_return);
            end
         end
         if (start && !busy) expected_rsp.insert(expected_rsp.size(), link_event(req_data));
         if (csr_we) begin
            case (csr_index)
               REG_FLIT_BITS: flit_bits = csr_wdata[FB_W-1:0];
               REG_VNS_IN_USE: vns_in_use = csr_wdata[3:0];
               REG_OUT_BUF_FLITS: begin
                  for (int i = 0; i < NVN; i++) obuf_credit[i] = csr_wdata;
               end
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== dv/credit_link_vn_controller_core_tb.sv =====
// Testbench top for the credit link controller: clock, reset, stimulus and
// verdict. Depends on clvc_pkg, the block and credit_link_vn_controller_core_checker.
`timescale 1ns / 100ps
module credit_link_vn_controller_core_tb;
   import clvc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_payload_type      req_data;
   logic                 rsp_valid;
   rsp_payload_type      rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending_count;
   logic                 transfer_seen;
   int                   idle_pct;
   int                   stuck_cycles;

   credit_link_vn_controller_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   credit_link_vn_controller_core_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending_count(pending_count), .transfer_seen(transfer_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: ends the run when nothing is transferred for too long.
   initial begin
      stuck_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || transfer_seen) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("credit_link_vn_controller_core: mismatch");
            $finish;
         end
      end
   end

   // One event transfer, with a random sender gap in front of it. Busy only
   // changes at a rising edge, so its value at the falling edge tells whether
   // the next rising edge takes the transfer. Start stays high on return.
   task automatic drive_event(input logic [2:0] act, input logic [2:0] vn,
                              input logic [15:0] bits, input logic [11:0] flits,
                              input logic [11:0] credits, input logic [15:0] tag);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{action: act, vn: vn, size_bits: bits, size_flits: flits,
                    credit_count: credits, packet_tag: tag};
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Random event mix: mostly well-formed traffic with small sizes on random VNs.
   task automatic random_event;
      int          r;
      logic [2:0]  act;
      logic [15:0] bits;
      r = $urandom_range(99);
      if (r < 22) act = ACT_SEND;
      else if (r < 30) act = ACT_QUERY;
      else if (r < 45) act = ACT_RECV;
      else if (r < 62) act = ACT_RCRED;
      else if (r < 78) act = ACT_RDATA;
      else if (r < 97) act = ACT_TICK;
      else act = 3'($urandom_range(6, 7));
      bits = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(512));
      drive_event(act, 3'($urandom), bits,
                  ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(20)),
                  ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(40)),
                  16'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: field extremes, every code and the special cases.
      drive_event(ACT_SEND, 3'd0, 16'd0, 12'd0, 12'd0, 16'h0000);
      drive_event(ACT_SEND, 3'd7, 16'hFFFF, 12'd0, 12'd0, 16'hFFFF);
      drive_event(ACT_SEND, 3'd1, 16'd100, 12'd0, 12'd0, 16'h1234);
      drive_event(ACT_QUERY, 3'd0, 16'hFFFF, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_QUERY, 3'd7, 16'd1, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_RECV, 3'd2, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_TICK, 3'd0, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_RCRED, 3'd1, 16'd0, 12'd0, 12'hFFF, 16'd0);
      drive_event(ACT_RCRED, 3'd1, 16'd0, 12'd0, 12'hFFF, 16'd0);
      drive_event(ACT_RCRED, 3'd0, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_TICK, 3'd0, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_TICK, 3'd0, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_RDATA, 3'd3, 16'd0, 12'hFFF, 12'd0, 16'hFFFF);
      drive_event(ACT_RDATA, 3'd3, 16'd0, 12'd0, 12'd0, 16'hA5A5);
      drive_event(ACT_RECV, 3'd3, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(ACT_RECV, 3'd3, 16'd0, 12'd0, 12'd0, 16'd0);
      drive_event(3'd6, 3'd5, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
      drive_event(3'd7, 3'd2, 16'd5, 12'd5, 12'd5, 16'd5);
      // A full incoming queue drops router data.
      for (int i = 0; i < 17; i++)
         drive_event(ACT_RDATA, 3'd4, 16'd0, 12'(i), 12'd0, 16'(i));
      drain();

      // Odd flit sizes and VN counts, including zero which acts as one.
      write_reg(REG_FLIT_BITS, 12'd0);
      write_reg(REG_VNS_IN_USE, 12'd0);
      write_reg(REG_OUT_BUF_FLITS, 12'd0);
      drive_event(ACT_SEND, 3'd0, 16'd1, 12'd0, 12'd0, 16'd9);
      drive_event(ACT_SEND, 3'd0, 16'd0, 12'd0, 12'd0, 16'd8);
      drive_event(ACT_SEND, 3'd1, 16'd0, 12'd0, 12'd0, 16'd7);
      drive_event(ACT_RCRED, 3'd1, 16'd0, 12'd0, 12'd3, 16'd0);
      drive_event(ACT_TICK, 3'd0, 16'd0, 12'd0, 12'd0, 16'd0);

      // Random phases over several configurations and idling levels.
      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: begin write_reg(REG_FLIT_BITS, 12'd1024); write_reg(REG_VNS_IN_USE, 12'd8);
                     write_reg(REG_OUT_BUF_FLITS, 12'd4095); idle_pct = 0; end
            1: begin write_reg(REG_FLIT_BITS, 12'd1); write_reg(REG_VNS_IN_USE, 12'd15);
                     write_reg(REG_OUT_BUF_FLITS, 12'd200); idle_pct = 75; end
            2: begin write_reg(REG_FLIT_BITS, 12'd64); write_reg(REG_VNS_IN_USE, 12'd3);
                     write_reg(REG_OUT_BUF_FLITS, 12'd60); idle_pct = 11; end
            3: begin write_reg(REG_FLIT_BITS, 12'd2047); write_reg(REG_VNS_IN_USE, 12'd1);
                     write_reg(REG_OUT_BUF_FLITS, 12'd1); idle_pct = 0; end
            4: begin write_reg(REG_FLIT_BITS, 12'd7); write_reg(REG_VNS_IN_USE, 12'd5);
                     write_reg(REG_OUT_BUF_FLITS, 12'd300); idle_pct = 75; end
            5: begin write_reg(REG_FLIT_BITS, 12'd32); write_reg(REG_VNS_IN_USE, 12'd8);
                     write_reg(REG_OUT_BUF_FLITS, 12'd1024); idle_pct = 0; end
            default: begin write_reg(REG_FLIT_BITS, 12'd16); write_reg(REG_VNS_IN_USE, 12'd6);
                     write_reg(REG_OUT_BUF_FLITS, 12'd4095); idle_pct = 11; end
         endcase
         for (int i = 0; i < 245; i++) random_event();
      end
      drain();

      if (fail_count == 0) begin
         $display("credit_link_vn_controller_core: match");
      end else begin
         $display("credit_link_vn_controller_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/clvc_pkg.sv
rtl/core/clvc_ram.sv
rtl/core/clvc_front.sv
rtl/core/clvc_back.sv
rtl/core/credit_link_vn_controller_core.sv
rtl/core/clvc_checker.sv
dv/credit_link_vn_controller_core_checker.sv
dv/credit_link_vn_controller_core_tb.sv
